// ===== src/kce_pkg.sv =====
package kce_pkg;

   localparam int MAX_DOCS_DEF     = 1024;
   localparam int MAX_SUBJECTS_DEF = 64;
   localparam int MAX_CLUSTERS_DEF = 16;

   localparam int SCORE_W = 16;
   localparam int MEAN_W  = 24;
   localparam int PASS_W  = 14;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_RUN    = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic RES_RUN  = 1'b0;
   localparam logic RES_READ = 1'b1;

   localparam logic [1:0] REG_CLUSTER_COUNT  = 2'd0;
   localparam logic [1:0] REG_DOCUMENT_COUNT = 2'd1;
   localparam logic [1:0] REG_SUBJECT_COUNT  = 2'd2;
   localparam logic [1:0] REG_PASS_LIMIT     = 2'd3;

   localparam logic [PASS_W-1:0] PASS_LIMIT_RESET = 14'd10000;

   typedef struct packed {
      logic [1:0]                kind;
      logic [9:0]                doc_index;
      logic [5:0]                subject_index;
      logic signed [SCORE_W-1:0] score;
   } req_word_type;

   typedef struct packed {
      logic              result_kind;
      logic [3:0]        cluster;
      logic [PASS_W-1:0] passes;
      logic              converged;
   } rsp_word_type;

   typedef struct packed {
      logic [4:0]        cluster_count;
      logic [10:0]       document_count;
      logic [6:0]        subject_count;
      logic [PASS_W-1:0] pass_limit;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_RESP,
      ST_INIT,
      ST_UPD_CLR,
      ST_ACC_A,
      ST_ACC_B,
      ST_ACC_C,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_DIV_RD,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_UPD_END,
      ST_MV_A,
      ST_MV_RD,
      ST_MV_DIFF,
      ST_MV_SQ,
      ST_MV_ACC,
      ST_MV_CMP,
      ST_MV_WB,
      ST_DONE
   } state_type;

endpackage

// ===== src/kce_divider.sv =====
module kce_divider #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic             fits;

   always_comb begin
      rem_sh  = {rem_ff, q_ff[NUM_W-1]};
      fits    = rem_sh >= {1'b0, den};
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = num;
         rem_in = '0;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         q_in    = {q_ff[NUM_W-2:0], fits};
         rem_in  = fits ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== src/kce_csr.sv =====
module kce_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output kce_pkg::cfg_type cfg
);
   import kce_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr;

   always_comb begin
      wr     = psel && penable && pwrite;
      cfg_in = cfg_ff;
      if (wr) begin
         case (paddr[3:2])
            REG_CLUSTER_COUNT:  cfg_in.cluster_count  = pwdata[4:0];
            REG_DOCUMENT_COUNT: cfg_in.document_count = pwdata[10:0];
            REG_SUBJECT_COUNT:  cfg_in.subject_count  = pwdata[6:0];
            REG_PASS_LIMIT:     cfg_in.pass_limit     = pwdata[PASS_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_CLUSTER_COUNT:  prdata = 32'(cfg_ff.cluster_count);
         REG_DOCUMENT_COUNT: prdata = 32'(cfg_ff.document_count);
         REG_SUBJECT_COUNT:  prdata = 32'(cfg_ff.subject_count);
         REG_PASS_LIMIT:     prdata = 32'(cfg_ff.pass_limit);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cluster_count  <= 5'd1;
         cfg_ff.document_count <= 11'd1;
         cfg_ff.subject_count  <= 7'd1;
         cfg_ff.pass_limit     <= PASS_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

// ===== src/kce_engine.sv =====
module kce_engine #(
   parameter int MAX_DOCS     = kce_pkg::MAX_DOCS_DEF,
   parameter int MAX_SUBJECTS = kce_pkg::MAX_SUBJECTS_DEF,
   parameter int MAX_CLUSTERS = kce_pkg::MAX_CLUSTERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kce_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kce_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kce_pkg::rsp_word_type rsp_data
);
   import kce_pkg::*;

   localparam int DOC_W  = $clog2(MAX_DOCS);
   localparam int DCNT_W = $clog2(MAX_DOCS + 1);
   localparam int SUB_W  = (MAX_SUBJECTS > 1) ? $clog2(MAX_SUBJECTS) : 1;
   localparam int SCNT_W = $clog2(MAX_SUBJECTS + 1);
   localparam int CL_W   = $clog2(MAX_CLUSTERS);
   localparam int KCNT_W = $clog2(MAX_CLUSTERS + 1);
   localparam int SA_W   = $clog2(MAX_DOCS * MAX_SUBJECTS);
   localparam int CA_W   = $clog2(MAX_CLUSTERS * MAX_SUBJECTS);
   localparam int SUM_W  = SCORE_W + DOC_W;
   localparam int SQ_W   = 2 * MEAN_W + 1;
   localparam int DIST_W = SQ_W + SCNT_W;
   localparam int NUM_W  = SUM_W + 10;
   localparam int DEN_W  = DCNT_W + 1;

   // storage
   logic signed [SCORE_W-1:0] score_ram_ff [MAX_DOCS*MAX_SUBJECTS];
   logic [CL_W-1:0]           assign_ram_ff [MAX_DOCS];
   logic signed [SUM_W-1:0]   sums_ram_ff [MAX_CLUSTERS*MAX_SUBJECTS];
   logic [DCNT_W-1:0]         cnt_ram_ff [MAX_CLUSTERS];
   logic signed [MEAN_W-1:0]  mean_ram_ff [MAX_CLUSTERS*MAX_SUBJECTS];

   logic signed [SCORE_W-1:0] score_rd_ff;
   logic [CL_W-1:0]           assign_rd_ff;
   logic signed [SUM_W-1:0]   sums_rd_ff;
   logic [DCNT_W-1:0]         cnt_rd_ff;
   logic signed [MEAN_W-1:0]  mean_rd_ff;

   logic                      score_we, score_re;
   logic [SA_W-1:0]           score_wa, score_ra;
   logic                      assign_we, assign_re;
   logic [DOC_W-1:0]          assign_wa, assign_ra;
   logic [CL_W-1:0]           assign_wd;
   logic                      sums_we, sums_re;
   logic [CA_W-1:0]           sums_a;
   logic signed [SUM_W-1:0]   sums_wd;
   logic                      cnt_we, cnt_re;
   logic [CL_W-1:0]           cnt_a;
   logic [DCNT_W-1:0]         cnt_wd;
   logic                      mean_we, mean_re;
   logic [CA_W-1:0]           mean_a;
   logic signed [MEAN_W-1:0]  mean_wd;

   state_type state_ff, state_in;

   logic [DOC_W-1:0]         i_ff, i_in;
   logic [SUB_W-1:0]         j_ff, j_in;
   logic [CL_W-1:0]          c_ff, c_in;
   logic [CL_W-1:0]          mod_ff, mod_in;
   logic [CL_W-1:0]          cl_ff, cl_in;
   logic [KCNT_W-1:0]        k_ff, k_in;
   logic [DCNT_W-1:0]        d_ff, d_in;
   logic [SCNT_W-1:0]        s_ff, s_in;
   logic [DCNT_W-1:0]        fill_ff, fill_in;
   logic [PASS_W-1:0]        pass_ff, pass_in;
   logic                     first_ff, first_in;
   logic                     moved_ff, moved_in;
   logic                     sign_ff, sign_in;
   logic                     hit_ff, hit_in;
   logic signed [MEAN_W:0]   diff_ff, diff_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [DIST_W-1:0]        acc_ff, acc_in;
   logic [DIST_W-1:0]        best_ff, best_in;
   logic [CL_W-1:0]          best_c_ff, best_c_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_data_ff, rsp_data_in;
   rsp_word_type             pend_ff, pend_in;

   logic                     last_i, last_j, last_c, rsp_free, accept;
   logic [PASS_W-1:0]        pass_inc;
   logic [SA_W-1:0]          doc_base;
   logic [CA_W-1:0]          cj_addr, clj_addr;
   logic [SUM_W-1:0]         mag;
   logic signed [2*MEAN_W+1:0] prod;
   logic                     div_start, div_done;
   logic [NUM_W-1:0]         div_num, div_quot;
   logic [DEN_W-1:0]         div_den;
   logic [MEAN_W-1:0]        q_mean;
   logic                     div_adv;

   kce_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      last_i   = (DCNT_W'(i_ff) == d_ff - 1'b1);
      last_j   = (SCNT_W'(j_ff) == s_ff - 1'b1);
      last_c   = (KCNT_W'(c_ff) == k_ff - 1'b1);
      rsp_free = !rsp_valid_ff || rsp_ready;
      accept   = req_valid && (state_ff == ST_IDLE);
      pass_inc = pass_ff + 1'b1;
      doc_base = SA_W'(i_ff) * SA_W'(MAX_SUBJECTS);
      cj_addr  = CA_W'(c_ff) * CA_W'(MAX_SUBJECTS) + CA_W'(j_ff);
      clj_addr = CA_W'(cl_ff) * CA_W'(MAX_SUBJECTS) + CA_W'(j_ff);
      mag      = sums_rd_ff[SUM_W-1] ? SUM_W'(-sums_rd_ff) : SUM_W'(sums_rd_ff);
      div_num  = NUM_W'({mag, 9'b0}) + NUM_W'(cnt_rd_ff);
      div_den  = {cnt_rd_ff, 1'b0};
      prod     = diff_ff * diff_ff;
      q_mean   = div_quot[MEAN_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.kind)
                  KIND_RUN:  state_in = ST_INIT;
                  KIND_READ: state_in = ST_READ;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:    state_in = ST_RESP;
         ST_RESP:    state_in = rsp_free ? ST_IDLE : ST_RESP;
         ST_INIT:    state_in = last_i ? ST_UPD_CLR : ST_INIT;
         ST_UPD_CLR: state_in = (last_j && last_c) ? ST_ACC_A : ST_UPD_CLR;
         ST_ACC_A:   state_in = ST_ACC_B;
         ST_ACC_B:   state_in = ST_ACC_C;
         ST_ACC_C:   state_in = ST_ACC_RD;
         ST_ACC_RD:  state_in = ST_ACC_WR;
         ST_ACC_WR: begin
            if (!last_j) state_in = ST_ACC_RD;
            else state_in = last_i ? ST_DIV_RD : ST_ACC_A;
         end
         ST_DIV_RD:  state_in = ST_DIV_GO;
         ST_DIV_GO: begin
            if (cnt_rd_ff != '0) state_in = ST_DIV_WAIT;
            else state_in = (last_j && last_c) ? ST_UPD_END : ST_DIV_RD;
         end
         ST_DIV_WAIT: begin
            if (div_done) state_in = (last_j && last_c) ? ST_UPD_END : ST_DIV_RD;
         end
         ST_UPD_END: begin
            if (first_ff || (moved_ff && pass_inc < cfg.pass_limit)) state_in = ST_MV_A;
            else state_in = ST_DONE;
         end
         ST_MV_A:    state_in = ST_MV_RD;
         ST_MV_RD:   state_in = ST_MV_DIFF;
         ST_MV_DIFF: state_in = ST_MV_SQ;
         ST_MV_SQ:   state_in = ST_MV_ACC;
         ST_MV_ACC:  state_in = last_j ? ST_MV_CMP : ST_MV_RD;
         ST_MV_CMP:  state_in = last_c ? ST_MV_WB : ST_MV_RD;
         ST_MV_WB:   state_in = last_i ? ST_UPD_CLR : ST_MV_A;
         ST_DONE:    state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      i_in = i_ff;  j_in = j_ff;  c_in = c_ff;  mod_in = mod_ff;  cl_in = cl_ff;
      k_in = k_ff;  d_in = d_ff;  s_in = s_ff;  fill_in = fill_ff;
      pass_in = pass_ff;  first_in = first_ff;  moved_in = moved_ff;
      sign_in = sign_ff;  hit_in = hit_ff;  diff_in = diff_ff;  sq_in = sq_ff;
      acc_in = acc_ff;  best_in = best_ff;  best_c_in = best_c_ff;  pend_in = pend_ff;

      score_we  = 1'b0;
      score_wa  = SA_W'(req_data.doc_index) * SA_W'(MAX_SUBJECTS)
                  + SA_W'(req_data.subject_index);
      score_re  = 1'b0;
      score_ra  = doc_base + SA_W'(j_ff);
      assign_we = 1'b0;
      assign_wa = i_ff;
      assign_wd = mod_ff;
      assign_re = 1'b0;
      assign_ra = i_ff;
      sums_we   = 1'b0;
      sums_re   = 1'b0;
      sums_a    = cj_addr;
      sums_wd   = '0;
      cnt_we    = 1'b0;
      cnt_re    = 1'b0;
      cnt_a     = c_ff;
      cnt_wd    = '0;
      mean_we   = 1'b0;
      mean_re   = 1'b0;
      mean_a    = cj_addr;
      mean_wd   = '0;
      div_start = 1'b0;
      div_adv   = 1'b0;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  KIND_LOAD: begin
                     score_we = (32'(req_data.doc_index) < MAX_DOCS)
                                && (32'(req_data.subject_index) < MAX_SUBJECTS);
                  end
                  KIND_RUN: begin
                     k_in = (cfg.cluster_count == '0) ? KCNT_W'(1) :
                            (32'(cfg.cluster_count) > MAX_CLUSTERS) ?
                            KCNT_W'(MAX_CLUSTERS) : KCNT_W'(cfg.cluster_count);
                     d_in = (cfg.document_count == '0) ? DCNT_W'(1) :
                            (32'(cfg.document_count) > MAX_DOCS) ?
                            DCNT_W'(MAX_DOCS) : DCNT_W'(cfg.document_count);
                     s_in = (cfg.subject_count == '0) ? SCNT_W'(1) :
                            (32'(cfg.subject_count) > MAX_SUBJECTS) ?
                            SCNT_W'(MAX_SUBJECTS) : SCNT_W'(cfg.subject_count);
                     i_in     = '0;
                     mod_in   = '0;
                     pass_in  = '0;
                     first_in = 1'b1;
                  end
                  KIND_READ: begin
                     hit_in    = (32'(req_data.doc_index) < MAX_DOCS)
                                 && (32'(req_data.doc_index) < 32'(fill_ff));
                     assign_re = 1'b1;
                     assign_ra = DOC_W'(req_data.doc_index);
                  end
                  default: begin
                     hit_in = hit_ff;
                  end
               endcase
            end
         end
         ST_READ: begin
            pend_in.result_kind = RES_READ;
            pend_in.cluster     = hit_ff ? 4'(assign_rd_ff) : 4'd0;
            pend_in.passes      = '0;
            pend_in.converged   = 1'b0;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
            end
         end
         ST_INIT: begin
            assign_we = 1'b1;
            mod_in = (KCNT_W'(mod_ff) + 1'b1 == k_ff) ? '0 : mod_ff + 1'b1;
            i_in   = i_ff + 1'b1;
            if (last_i) begin
               fill_in = (fill_ff > d_ff) ? fill_ff : d_ff;
               c_in = '0;
               j_in = '0;
            end
         end
         ST_UPD_CLR: begin
            sums_we = 1'b1;
            cnt_we  = (j_ff == '0);
            if (last_j) begin
               j_in = '0;
               c_in = c_ff + 1'b1;
               if (last_c) i_in = '0;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_ACC_A: begin
            assign_re = 1'b1;
         end
         ST_ACC_B: begin
            cl_in  = assign_rd_ff;
            cnt_re = 1'b1;
            cnt_a  = assign_rd_ff;
         end
         ST_ACC_C: begin
            cnt_we = 1'b1;
            cnt_a  = cl_ff;
            cnt_wd = cnt_rd_ff + 1'b1;
            j_in   = '0;
         end
         ST_ACC_RD: begin
            score_re = 1'b1;
            sums_re  = 1'b1;
            sums_a   = clj_addr;
         end
         ST_ACC_WR: begin
            sums_we = 1'b1;
            sums_a  = clj_addr;
            sums_wd = sums_rd_ff + {{(SUM_W-SCORE_W){score_rd_ff[SCORE_W-1]}}, score_rd_ff};
            if (last_j) begin
               j_in = '0;
               if (last_i) c_in = '0;
               else i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DIV_RD: begin
            sums_re = 1'b1;
            cnt_re  = 1'b1;
         end
         ST_DIV_GO: begin
            sign_in = sums_rd_ff[SUM_W-1];
            if (cnt_rd_ff != '0) begin
               div_start = 1'b1;
            end else begin
               mean_we = 1'b1;
               div_adv = 1'b1;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               mean_we = 1'b1;
               mean_wd = sign_ff ? MEAN_W'(-q_mean) : q_mean;
               div_adv = 1'b1;
            end
         end
         ST_UPD_END: begin
            pass_in  = pass_inc;
            first_in = 1'b0;
            moved_in = (state_in == ST_MV_A) ? 1'b0 : moved_ff;
            i_in     = '0;
         end
         ST_MV_A: begin
            assign_re = 1'b1;
            c_in   = '0;
            j_in   = '0;
            acc_in = '0;
         end
         ST_MV_RD: begin
            score_re = 1'b1;
            mean_re  = 1'b1;
         end
         ST_MV_DIFF: begin
            diff_in = {score_rd_ff[SCORE_W-1], score_rd_ff, 8'h00}
                      - {mean_rd_ff[MEAN_W-1], mean_rd_ff};
         end
         ST_MV_SQ: begin
            sq_in = prod[SQ_W-1:0];
         end
         ST_MV_ACC: begin
            acc_in = acc_ff + DIST_W'(sq_ff);
            j_in   = last_j ? '0 : j_ff + 1'b1;
         end
         ST_MV_CMP: begin
            if (c_ff == '0 || acc_ff < best_ff) begin
               best_in   = acc_ff;
               best_c_in = c_ff;
            end
            acc_in = '0;
            j_in   = '0;
            c_in   = c_ff + 1'b1;
         end
         ST_MV_WB: begin
            assign_wd = best_c_ff;
            if (assign_rd_ff != best_c_ff) begin
               assign_we = 1'b1;
               moved_in  = 1'b1;
            end
            i_in = i_ff + 1'b1;
            if (last_i) begin
               c_in = '0;
               j_in = '0;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = RES_RUN;
               rsp_data_in.cluster     = 4'd0;
               rsp_data_in.passes      = pass_ff;
               rsp_data_in.converged   = !moved_ff;
            end
         end
         default: begin
            i_in = i_ff;
         end
      endcase

      if (div_adv) begin
         if (last_j) begin
            j_in = '0;
            c_in = c_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;  j_ff <= j_in;  c_ff <= c_in;  mod_ff <= mod_in;  cl_ff <= cl_in;
      k_ff <= k_in;  d_ff <= d_in;  s_ff <= s_in;
      pass_ff <= pass_in;  first_ff <= first_in;  moved_ff <= moved_in;
      sign_ff <= sign_in;  hit_ff <= hit_in;  diff_ff <= diff_in;  sq_ff <= sq_in;
      acc_ff <= acc_in;  best_ff <= best_in;  best_c_ff <= best_c_in;
      pend_ff <= pend_in;  rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (score_we) score_ram_ff[score_wa] <= req_data.score;
      if (score_re) score_rd_ff <= score_ram_ff[score_ra];
   end

   always_ff @(posedge clock) begin
      if (assign_we) assign_ram_ff[assign_wa] <= assign_wd;
      if (assign_re) assign_rd_ff <= assign_ram_ff[assign_ra];
   end

   always_ff @(posedge clock) begin
      if (sums_we) sums_ram_ff[sums_a] <= sums_wd;
      if (sums_re) sums_rd_ff <= sums_ram_ff[sums_a];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_ram_ff[cnt_a] <= cnt_wd;
      if (cnt_re) cnt_rd_ff <= cnt_ram_ff[cnt_a];
   end

   always_ff @(posedge clock) begin
      if (mean_we) mean_ram_ff[mean_a] <= mean_wd;
      if (mean_re) mean_rd_ff <= mean_ram_ff[mean_a];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/kmeans_cluster_engine_top.sv =====
// Lloyd k-means engine. A load word writes one Q8.8 score; a read word is answered by one
// result word. A run word holds the input until its report is issued: initial assignment,
// then per pass a clear of the sums, accumulation, the mean divisions (one quotient bit per
// cycle; an empty cluster gets a zero mean without a division) and a decision, and, on every
// pass after the first, a move step that reads the score and mean memory ports for each
// distance term.
module kmeans_cluster_engine_top #(
   parameter int MAX_DOCS     = kce_pkg::MAX_DOCS_DEF,
   parameter int MAX_SUBJECTS = kce_pkg::MAX_SUBJECTS_DEF,
   parameter int MAX_CLUSTERS = kce_pkg::MAX_CLUSTERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kce_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kce_pkg::rsp_word_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import kce_pkg::*;

   cfg_type cfg;

   kce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   kce_engine #(
      .MAX_DOCS     (MAX_DOCS),
      .MAX_SUBJECTS (MAX_SUBJECTS),
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sim/tb_kmeans_cluster_engine_top.sv =====
module tb_kmeans_cluster_engine_top;
   timeunit 1ns;
   timeprecision 1ps;
   import kce_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [3:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   kmeans_cluster_engine_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow state of the engine
   shortint    score_mem [0:MAX_DOCS_DEF-1][0:MAX_SUBJECTS_DEF-1];
   bit         written [0:MAX_DOCS_DEF-1][0:MAX_SUBJECTS_DEF-1];
   logic [3:0] cluster_of [0:MAX_DOCS_DEF-1];
   longint     mean_mem [0:MAX_CLUSTERS_DEF-1][0:MAX_SUBJECTS_DEF-1];
   int         pass_cnt;
   cfg_type    cfg;

   rsp_word_type expected_rsp [$];
   int errors = 0;
   int items_sent = 0;
   int runs_done = 0;
   int runs_converged = 0;
   int reads_done = 0;
   int loads_done = 0;
   bit quiet = 1'b0;
   int stall_left = 0;

   function automatic int clamp_count(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void recompute_means(int k, int d, int s);
      longint sums [0:MAX_CLUSTERS_DEF-1][0:MAX_SUBJECTS_DEF-1];
      int     members [0:MAX_CLUSTERS_DEF-1];
      longint mag;
      longint q;
      int     c;
      for (int ci = 0; ci < k; ci++) begin
         members[ci] = 0;
         for (int j = 0; j < s; j++) sums[ci][j] = 0;
      end
      for (int i = 0; i < d; i++) begin
         c = cluster_of[i];
         if (c < k) begin
            members[c]++;
            for (int j = 0; j < s; j++) sums[c][j] += score_mem[i][j];
         end
      end
      for (int ci = 0; ci < k; ci++)
         for (int j = 0; j < s; j++) begin
            mean_mem[ci][j] = 0;
            if (members[ci] != 0) begin
               mag = sums[ci][j] < 0 ? -sums[ci][j] : sums[ci][j];
               q = (mag * 512 + members[ci]) / (2 * members[ci]);
               mean_mem[ci][j] = sums[ci][j] < 0 ? -q : q;
            end
         end
      pass_cnt++;
   endfunction

   function automatic bit reassign(int k, int d, int s);
      longint unsigned best;
      longint unsigned dist_sum;
      longint          diff;
      int              best_c;
      bit              moved;
      moved = 1'b0;
      for (int i = 0; i < d; i++) begin
         best = 0;
         best_c = 0;
         for (int c = 0; c < k; c++) begin
            dist_sum = 0;
            for (int j = 0; j < s; j++) begin
               diff = longint'(score_mem[i][j]) * 256 - mean_mem[c][j];
               if (diff < 0) diff = -diff;
               dist_sum += longint'(diff) * diff;
            end
            if (c == 0 || dist_sum < best) begin
               best = dist_sum;
               best_c = c;
            end
         end
         if (cluster_of[i] != best_c) begin
            cluster_of[i] = 4'(best_c);
            moved = 1'b1;
         end
      end
      return moved;
   endfunction

   function automatic void predict_word(req_word_type w);
      rsp_word_type r;
      int  k, d, s;
      bit  moved;
      r = '0;
      case (w.kind)
         KIND_LOAD: begin
            score_mem[w.doc_index][w.subject_index] = w.score;
            written[w.doc_index][w.subject_index] = 1'b1;
            loads_done++;
         end
         KIND_RUN: begin
            k = clamp_count(cfg.cluster_count, MAX_CLUSTERS_DEF);
            d = clamp_count(cfg.document_count, MAX_DOCS_DEF);
            s = clamp_count(cfg.subject_count, MAX_SUBJECTS_DEF);
            for (int i = 0; i < d; i++) cluster_of[i] = 4'(i % k);
            pass_cnt = 0;
            recompute_means(k, d, s);
            do begin
               moved = reassign(k, d, s);
               recompute_means(k, d, s);
            end while (moved && pass_cnt < cfg.pass_limit);
            r.result_kind = RES_RUN;
            r.passes = PASS_W'(pass_cnt);
            r.converged = !moved;
            runs_done++;
            if (!moved) runs_converged++;
            expected_rsp.push_back(r);
         end
         KIND_READ: begin
            r.result_kind = RES_READ;
            r.cluster = cluster_of[w.doc_index];
            reads_done++;
            expected_rsp.push_back(r);
         end
         default: ;
      endcase
   endfunction

   task automatic send_word(req_word_type w);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      predict_word(w);
      if (w.kind != KIND_UNUSED) items_sent++;
   endtask

   task automatic send_fields(logic [1:0] kind, int doc, int subj, int score);
      req_word_type w;
      w.kind = kind;
      w.doc_index = 10'(doc);
      w.subject_index = 6'(subj);
      w.score = 16'(score);
      send_word(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // drain first: registers change only while the engine is idle
   task automatic write_settings(int k, int d, int s, int lim);
      int vals [4];
      int widths [4];
      drain();
      vals = '{k, d, s, lim};
      widths = '{5, 11, 7, PASS_W};
      for (int i = 0; i < 4; i++) begin
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b1;
         paddr <= {i[1:0], 2'b00};
         pwdata <= ($urandom << widths[i]) | vals[i];
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cfg.cluster_count = 5'(k);
      cfg.document_count = 11'(d);
      cfg.subject_count = 7'(s);
      cfg.pass_limit = PASS_W'(lim);
   endtask

   // mode 0 full-range random, 1 grouped around a few centers, 2 constant
   task automatic fill_scores(int mode, bit only_missing);
      int d, s, v, g;
      int centers [4];
      d = clamp_count(cfg.document_count, MAX_DOCS_DEF);
      s = clamp_count(cfg.subject_count, MAX_SUBJECTS_DEF);
      for (int c = 0; c < 4; c++) centers[c] = $urandom_range(0, 60000) - 30000;
      v = $urandom_range(0, 65535) - 32768;
      for (int i = 0; i < d; i++) begin
         g = $urandom_range(0, 3);
         for (int j = 0; j < s; j++) begin
            if (!only_missing || !written[i][j]) begin
               case (mode)
                  0: v = $urandom_range(0, 65535) - 32768;
                  1: v = centers[(g + j) % 4] + $urandom_range(0, 1600) - 800;
                  default: ;
               endcase
               send_fields(KIND_LOAD, i, j, v);
            end
         end
      end
   endtask

   task automatic run_and_read(int extra);
      int d;
      d = clamp_count(cfg.document_count, MAX_DOCS_DEF);
      send_fields(KIND_RUN, $urandom_range(0, 1023), $urandom_range(0, 63),
                  $urandom_range(0, 65535));
      for (int i = 0; i < d + extra && i < 20; i++) send_fields(KIND_READ, i, 0, 0);
   endtask

   task automatic test_directed_words();
      send_fields(KIND_READ, 0, 0, 0);
      send_fields(KIND_READ, 1023, 63, -1);
      send_fields(KIND_UNUSED, 5, 5, 5);
      send_fields(KIND_LOAD, 1023, 63, -32768);
      send_fields(KIND_LOAD, 0, 0, 32767);
      send_fields(KIND_LOAD, 512, 32, 0);
      send_fields(KIND_UNUSED, 1023, 63, -1);
      send_fields(KIND_READ, 1023, 0, 0);
      // reset settings: one cluster, one document, one subject
      send_fields(KIND_RUN, 0, 0, 0);
      send_fields(KIND_READ, 0, 0, 0);
   endtask

   task automatic test_register_extremes();
      // zero registers saturate to one, zero pass limit stops early
      write_settings(0, 0, 0, 0);
      fill_scores(0, 1'b1);
      run_and_read(1);
      // more clusters than documents leaves clusters empty; subjects saturate
      write_settings(31, 1, 127, 1);
      fill_scores(0, 1'b1);
      run_and_read(2);
      // equal scores everywhere: every tie goes to the lowest cluster
      write_settings(4, 8, 2, 10000);
      fill_scores(2, 1'b0);
      run_and_read(0);
      write_settings(16, 16, 1, 10000);
      fill_scores(1, 1'b0);
      run_and_read(0);
      write_settings(16, 16, 1, 16383);
      send_fields(KIND_LOAD, 3, 0, -32768);
      send_fields(KIND_LOAD, 4, 0, 32767);
      run_and_read(0);
      // full document store
      write_settings(2, 2047, 1, 1);
      fill_scores(0, 1'b1);
      run_and_read(0);
      write_settings(1, 1024, 64, 10000);
      write_settings(2, 2, 64, 2);
      fill_scores(0, 1'b1);
      run_and_read(0);
   endtask

   task automatic test_random_runs();
      int k, d, s, lim, n;
      while (items_sent < 1350) begin
         if (items_sent > 1280) quiet = 1'b1;
         k = $urandom_range(0, 7) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 16);
         d = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 12);
         s = $urandom_range(1, 3);
         lim = $urandom_range(0, 3) == 0 ? 10000 : $urandom_range(0, 8);
         write_settings(k, d, s, lim);
         fill_scores($urandom_range(0, 3) == 0 ? 0 : 1, 1'b0);
         n = $urandom_range(0, 4);
         for (int i = 0; i < n; i++)
            send_fields(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                        $urandom_range(0, 63), $urandom_range(0, 65535));
         run_and_read($urandom_range(0, 2));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", rsp_data);
         end else begin
            exp_w = expected_rsp.pop_front();
            if (rsp_data.result_kind !== exp_w.result_kind ||
                rsp_data.cluster !== exp_w.cluster ||
                rsp_data.passes !== exp_w.passes ||
                rsp_data.converged !== exp_w.converged) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                           exp_w.result_kind, exp_w.cluster, exp_w.passes, exp_w.converged,
                           rsp_data.result_kind, rsp_data.cluster, rsp_data.passes,
                           rsp_data.converged);
            end
         end
      end
   end

   initial begin
      #200_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      cfg.cluster_count = 1;
      cfg.document_count = 1;
      cfg.subject_count = 1;
      cfg.pass_limit = PASS_LIMIT_RESET;
      for (int i = 0; i < MAX_DOCS_DEF; i++) cluster_of[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_words();
      test_register_extremes();
      test_random_runs();
      drain();
      repeat (50) @(posedge clock);
      errors += expected_rsp.size();
      $display("covered %0d words: %0d loads, %0d reads, %0d runs (%0d converged)",
               items_sent, loads_done, reads_done, runs_done, runs_converged);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== kmeans_cluster_engine_top.f =====
src/kce_pkg.sv
src/kce_divider.sv
src/kce_csr.sv
src/kce_engine.sv
src/kmeans_cluster_engine_top.sv
sim/tb_kmeans_cluster_engine_top.sv
